@@ rtl/core/rhsd_pkg.sv @@
// Shared types and constants of the RGB half-scale box downsampler.
package rhsd_pkg;

   localparam int CH_W  = 8;           // one color channel
   localparam int SUM_W = CH_W + 1;    // sum of two channel samples
   localparam int ACC_W = CH_W + 2;    // sum of four channel samples
   localparam int PIX_W = 3 * CH_W;    // packed pixel, red low
   localparam int ENT_W = 3 * SUM_W;   // packed pair sums, red low
   localparam int CFG_W = 13;          // size register width
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [SUM_W-1:0] pair_sum_type;
   typedef logic [ENT_W-1:0] entry_type;

endpackage

@@ rtl/core/rgb_half_scale_box_downsampler_top.sv @@
// Top level of the RGB half-scale 2x2 box downsampler with its line store.
// Usage
//   req_*  : input pixels (8-bit red, green, blue) in raster order, valid/ready.
//   rsp_*  : one averaged pixel per 2x2 block, valid/ready; rsp_frame_end marks
//            the last block of the frame.
//   csr_*  : APB-style port. Offset 0x0 holds image_width, 0x4 image_height
//            (13 bits each). Write them only while no item is in flight.
//   Each result channel is the floor of the four-sample mean; an odd width
//   drops column 0, an odd height drops the last row.
// Timing
//   One item is taken every clock while req_ready is high. For an item
//   completing a block (the right pixel of a pair on an odd row) the line
//   store read and fetch stage load as it is taken; the final add enters the
//   output register, raising rsp_valid, when the fetch stage advances.
//   Pair sums of even rows go to a MAX_WIDTH/2-entry line store, one write
//   or one read per item, so the store port sets the one-item-per-clock rate.
// Reset and stall
//   Reset clears counters, pipeline valids and restores sizes 640 x 480.
//   The line store is not cleared; every entry is written before it is read.
//   A stalled receiver holds the output register; the fetch stage holds too,
//   and req_ready drops only when both stages are full and the receiver stalls.
module rgb_half_scale_box_downsampler_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   // input pixels
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rhsd_pkg::chan_type           req_red,
   input  rhsd_pkg::chan_type           req_green,
   input  rhsd_pkg::chan_type           req_blue,
   // averaged pixels
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rhsd_pkg::chan_type           rsp_avg_red,
   output rhsd_pkg::chan_type           rsp_avg_green,
   output rhsd_pkg::chan_type           rsp_avg_blue,
   output logic                         rsp_frame_end,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rhsd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rhsd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [rhsd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import rhsd_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AW  = $clog2(LINE_DEPTH);       // line store address
   localparam int CW  = $clog2(MAX_WIDTH);        // column counter
   localparam int RW  = $clog2(MAX_HEIGHT);       // row counter
   localparam int WW  = $clog2(MAX_WIDTH + 1);    // clamped width
   localparam int HW  = $clog2(MAX_HEIGHT + 1);   // clamped height
   localparam int XW  = (WW > CFG_W) ? WW : CFG_W;
   localparam int YW  = (HW > CFG_W) ? HW : CFG_W;

   // ---------------------------------------------------------------------
   // Configuration registers; keep a clamped copy of each size
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [WW-1:0]    wlim_ff, wlim_in;
   logic [HW-1:0]    hlim_ff, hlim_in;
   logic             csr_wr;
   reg_index_type    csr_idx;
   logic [XW-1:0]    wide_w;
   logic [YW-1:0]    wide_h;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr && csr_idx == REG_WIDTH) begin
         width_in = csr_pwdata[CFG_W-1:0];
      end
      if (csr_wr && csr_idx == REG_HEIGHT) begin
         height_in = csr_pwdata[CFG_W-1:0];
      end
      // zero counts as one, oversize saturates at the store limits
      wide_w = XW'(width_in);
      wide_h = YW'(height_in);
      if (wide_w == '0) begin
         wlim_in = WW'(1);
      end else if (wide_w > XW'(MAX_WIDTH)) begin
         wlim_in = WW'(MAX_WIDTH);
      end else begin
         wlim_in = wide_w[WW-1:0];
      end
      if (wide_h == '0) begin
         hlim_in = HW'(1);
      end else if (wide_h > YW'(MAX_HEIGHT)) begin
         hlim_in = HW'(MAX_HEIGHT);
      end else begin
         hlim_in = wide_h[HW-1:0];
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Input stage: position decode, pair sum, line store access
   // ---------------------------------------------------------------------
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic             accept;
   logic             in_frame;
   logic [CW-1:0]    pos;
   logic [CW-2:0]    idx_full;
   logic             idx_ok;
   logic [AW-1:0]    addr;
   logic [HW-1:0]    used_rows;
   logic [WW-1:0]    col_next;
   logic [HW-1:0]    row_next;
   logic             pair_right;
   logic             wr_en, rd_en, gen;
   logic             last_blk;
   pair_sum_type     sum_r, sum_g, sum_b;
   entry_type        pair_sum;

   assign accept    = req_valid && req_ready;
   assign used_rows = {hlim_ff[HW-1:1], 1'b0};
   assign col_next  = WW'(col_ff) + WW'(1);
   assign row_next  = HW'(row_ff) + HW'(1);
   assign in_frame  = (WW'(col_ff) < wlim_ff) && (HW'(row_ff) < used_rows)
                      && (col_ff >= CW'(wlim_ff[0]));
   assign pos       = col_ff - CW'(wlim_ff[0]);
   assign idx_full  = pos[CW-1:1];
   assign idx_ok    = (CW'(idx_full) < CW'(LINE_DEPTH));
   assign addr      = idx_full[AW-1:0];
   assign pair_right = in_frame && pos[0];

   assign sum_r    = SUM_W'(left_ff[CH_W-1:0]) + SUM_W'(req_red);
   assign sum_g    = SUM_W'(left_ff[2*CH_W-1:CH_W]) + SUM_W'(req_green);
   assign sum_b    = SUM_W'(left_ff[3*CH_W-1:2*CH_W]) + SUM_W'(req_blue);
   assign pair_sum = {sum_b, sum_g, sum_r};

   // even row: store the pair; odd row: fetch the upper pair and emit
   assign wr_en    = accept && pair_right && !row_ff[0] && idx_ok;
   assign gen      = accept && pair_right && row_ff[0];
   assign rd_en    = gen && idx_ok;
   assign last_blk = (row_next == used_rows)
                     && (WW'(idx_full) + WW'(1) == WW'(wlim_ff[WW-1:1]));

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (in_frame && !pos[0]) begin
            left_in = {req_blue, req_green, req_red};
         end
         if (col_next >= wlim_ff) begin
            col_in = '0;
            row_in = (row_next >= hlim_ff) ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   // line store: one write or one read per item, registered read data
   entry_type line_mem [LINE_DEPTH];
   entry_type mem_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[addr] <= pair_sum;
      end
      if (rd_en) begin
         mem_rd_ff <= line_mem[addr];
      end
   end

   // ---------------------------------------------------------------------
   // Fetch stage: pair sum of the lower row waits for the store read
   // ---------------------------------------------------------------------
   logic      s1_valid_ff, s1_valid_in;
   entry_type s1_sum_ff, s1_sum_in;
   logic      s1_hit_ff, s1_hit_in;
   logic      s1_last_ff, s1_last_in;
   logic      s1_adv;
   entry_type upper;

   assign s1_adv    = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sum_in   = s1_sum_ff;
      s1_hit_in   = s1_hit_ff;
      s1_last_in  = s1_last_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (gen) begin
         s1_valid_in = 1'b1;
         s1_sum_in   = pair_sum;
         s1_hit_in   = idx_ok;
         s1_last_in  = last_blk;
      end
   end

   // an index past the store reads as zero
   assign upper = s1_hit_ff ? mem_rd_ff : '0;

   // ---------------------------------------------------------------------
   // Output register: add the two pair sums, drop the low two bits
   // ---------------------------------------------------------------------
   logic     out_valid_ff, out_valid_in;
   chan_type out_r_ff, out_r_in;
   chan_type out_g_ff, out_g_in;
   chan_type out_b_ff, out_b_in;
   logic     out_last_ff, out_last_in;
   logic [ACC_W-1:0] acc_r, acc_g, acc_b;

   assign acc_r = ACC_W'(upper[SUM_W-1:0]) + ACC_W'(s1_sum_ff[SUM_W-1:0]);
   assign acc_g = ACC_W'(upper[2*SUM_W-1:SUM_W]) + ACC_W'(s1_sum_ff[2*SUM_W-1:SUM_W]);
   assign acc_b = ACC_W'(upper[3*SUM_W-1:2*SUM_W])
                  + ACC_W'(s1_sum_ff[3*SUM_W-1:2*SUM_W]);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_r_in     = out_r_ff;
      out_g_in     = out_g_ff;
      out_b_in     = out_b_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_r_in     = acc_r[ACC_W-1:2];
         out_g_in     = acc_g[ACC_W-1:2];
         out_b_in     = acc_b[ACC_W-1:2];
         out_last_in  = s1_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_avg_red   = out_r_ff;
   assign rsp_avg_green = out_g_ff;
   assign rsp_avg_blue  = out_b_ff;
   assign rsp_frame_end = out_last_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         wlim_ff      <= WW'(WIDTH_RST);
         hlim_ff      <= HW'(HEIGHT_RST);
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         wlim_ff      <= wlim_in;
         hlim_ff      <= hlim_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff   <= s1_sum_in;
      s1_hit_ff   <= s1_hit_in;
      s1_last_ff  <= s1_last_in;
      out_r_ff    <= out_r_in;
      out_g_ff    <= out_g_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store written and read by the same item");

   a_fetch_loaded: assert property (@(posedge clock) disable iff (reset)
      gen |=> s1_valid_ff)
      else $error("block item lost before the fetch stage");

   a_fetch_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_sum_ff)
                                 && $stable(mem_rd_ff))
      else $error("stalled fetch stage changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ready)
      else $error("input taken while both stages are full");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the RGB half-scale 2x2 box downsampler.
module tb;
   import rhsd_pkg::*;

   localparam int MAX_W        = 4096;
   localparam int MAX_H        = 4096;
   localparam int LINE_DEPTH   = MAX_W / 2;
   localparam int SETTLE       = 8;       // cycles to let a resultless item clear the pipe
   localparam int HOLD_CYCLES  = 400;     // one long receiver back-off
   localparam int IDLE_PCT     = 6;       // idle chance per cycle on each side
   localparam int RANDOM_ITEMS = 1300;
   localparam int REPORT_MAX   = 10;
   localparam int LIMIT        = 400000;  // cycles before the run is declared hung

   // one averaged output pixel, in port order
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     frame_end;
   } avg_pixel_type;

   // Holds a private copy of the sizes, counters and pair-sum line, and the
   // queue of averaged pixels still owed by the block.
   class block_avg_scoreboard;
      entry_type        row_sums [LINE_DEPTH];
      logic [PIX_W-1:0] held_left;
      int unsigned      col_pos;
      int unsigned      row_pos;
      logic [CFG_W-1:0] cfg_width;
      logic [CFG_W-1:0] cfg_height;
      avg_pixel_type    expected_avgs [$];
      int unsigned      mismatches;

      function new();
         foreach (row_sums[i]) row_sums[i] = '0;
         held_left  = '0;
         col_pos    = 0;
         row_pos    = 0;
         cfg_width  = WIDTH_RST;
         cfg_height = HEIGHT_RST;
         mismatches = 0;
      endfunction

      // zero acts as one, anything past the maximum acts as the maximum
      static function int unsigned clip_size(logic [CFG_W-1:0] v, int unsigned top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      function void set_size(reg_index_type idx, logic [CFG_W-1:0] v);
         if (idx == REG_WIDTH) cfg_width = v;
         else cfg_height = v;
      endfunction

      function int unsigned frame_pixels();
         return clip_size(cfg_width, MAX_W) * clip_size(cfg_height, MAX_H);
      endfunction

      function bit at_frame_start();
         return col_pos == 0 && row_pos == 0;
      endfunction

      function int unsigned pending();
         return expected_avgs.size();
      endfunction

      function void note_pixel(chan_type r, chan_type g, chan_type b);
         int unsigned      w, h, skip, rows_used, p, idx;
         pair_sum_type     sr, sg, sb;
         entry_type        upper;
         logic [ACC_W-1:0] ar, ag, ab;
         avg_pixel_type    avg;
         w         = clip_size(cfg_width, MAX_W);
         h         = clip_size(cfg_height, MAX_H);
         skip      = w % 2;
         rows_used = h - h % 2;
         if (col_pos < w && row_pos < rows_used && col_pos >= skip) begin
            p = col_pos - skip;
            if (p % 2 == 0) begin
               held_left = {b, g, r};
            end else begin
               idx = p / 2;
               sr  = pair_sum_type'(held_left[CH_W-1:0]) + pair_sum_type'(r);
               sg  = pair_sum_type'(held_left[2*CH_W-1:CH_W]) + pair_sum_type'(g);
               sb  = pair_sum_type'(held_left[3*CH_W-1:2*CH_W]) + pair_sum_type'(b);
               if (row_pos % 2 == 0) begin
                  row_sums[idx] = {sb, sg, sr};
               end else begin
                  upper = row_sums[idx];
                  ar = ACC_W'(upper[SUM_W-1:0]) + ACC_W'(sr);
                  ag = ACC_W'(upper[2*SUM_W-1:SUM_W]) + ACC_W'(sg);
                  ab = ACC_W'(upper[3*SUM_W-1:2*SUM_W]) + ACC_W'(sb);
                  avg.red       = ar[ACC_W-1:2];
                  avg.green     = ag[ACC_W-1:2];
                  avg.blue      = ab[ACC_W-1:2];
                  avg.frame_end = (row_pos == rows_used - 1) && (idx == w / 2 - 1);
                  expected_avgs.push_back(avg);
               end
            end
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      endfunction

      function void check_avg(avg_pixel_type got);
         avg_pixel_type want;
         if (expected_avgs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected averaged pixel: r=%0d g=%0d b=%0d end=%0b",
                        got.red, got.green, got.blue, got.frame_end);
            return;
         end
         want = expected_avgs.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("averaged pixel mismatch: expected r=%0d g=%0d b=%0d end=%0b,",
                        want.red, want.green, want.blue, want.frame_end,
                        " got r=%0d g=%0d b=%0d end=%0b",
                        got.red, got.green, got.blue, got.frame_end);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   chan_type          req_red, req_green, req_blue;
   logic              rsp_valid;
   logic              rsp_ready;
   chan_type          rsp_avg_red, rsp_avg_green, rsp_avg_blue;
   logic              rsp_frame_end;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   bit                steady;        // both sides stream with no idling
   bit                hold_req;      // ask the receiver for its long back-off
   int unsigned       pixels_sent;
   int unsigned       cycle_count = 0;
   block_avg_scoreboard sb;

   rgb_half_scale_box_downsampler_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_avg_red   (rsp_avg_red),
      .rsp_avg_green (rsp_avg_green),
      .rsp_avg_blue  (rsp_avg_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   // Bail out if the block hangs; a correct run ends far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Check every averaged pixel taken by the receiver against the oldest
   // expectation. Sampled at the edge, so pre-edge values are seen.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_avg({rsp_avg_red, rsp_avg_green, rsp_avg_blue, rsp_frame_end});
   end

   // Receiver: random back-pressure, none while streaming steadily, and
   // one long hold-off on request so the block fills and stalls req_ready.
   initial begin : receiver
      int unsigned hold_left;
      bit          hold_used;
      hold_left = 0;
      hold_used = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_used) begin
            hold_used = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Bias channel values toward the extremes so saturated sums show up often.
   function automatic chan_type rand_chan();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return chan_type'($urandom);
      endcase
   endfunction

   // Offer one pixel, idling first at random, and hold it until taken.
   // The prediction is advanced at the accepting edge.
   task automatic send_pixel(chan_type r, chan_type g, chan_type b);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(r, g, b);
      pixels_sent++;
   endtask

   task automatic send_random();
      send_pixel(rand_chan(), rand_chan(), rand_chan());
   endtask

   // Feed pixels until the counters wrap back to the top-left corner.
   task automatic finish_frame();
      while (!sb.at_frame_start()) send_random();
   endtask

   task automatic send_frame();
      send_random();
      finish_frame();
   endtask

   // Drop valid, wait out every owed result, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Setup cycle then access cycle; junk in the upper data bits is ignored.
   task automatic write_reg(reg_index_type idx, logic [CFG_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= {(CSR_DW-CFG_W)'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_size(idx, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      drain();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   initial begin : stimulus
      int unsigned random_start, w, h, npix, cut;
      sb          = new();
      steady      <= 1'b0;
      hold_req    <= 1'b0;
      pixels_sent = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_red     <= '0;
      req_green   <= '0;
      req_blue    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes (640 x 480): take four pixels of the top row, then shrink
      // to 4 x 2 mid-frame; the fifth pixel is ignored and ends the row.
      repeat (4) send_random();
      drain();
      write_reg(REG_WIDTH, CFG_W'(4));
      write_reg(REG_HEIGHT, CFG_W'(2));
      finish_frame();

      // Stream a 64 x 4 frame with no idling on either side; this also
      // writes every line entry that later frames and resizes can reach.
      steady <= 1'b1;
      set_frame(CFG_W'(64), CFG_W'(4));
      send_frame();
      drain();
      steady <= 1'b0;

      // Oversized width clamps to the even maximum, so no column is dropped:
      // take eight pixels of the top row, then narrow to eight columns.
      set_frame(CFG_W'(8191), CFG_W'(2));
      repeat (8) send_random();
      drain();
      write_reg(REG_WIDTH, CFG_W'(8));
      finish_frame();

      // Directed: all-ones block, floor of a non-multiple of four,
      // odd width and odd height, and the degenerate zero/one sizes.
      set_frame(CFG_W'(2), CFG_W'(2));
      repeat (4) send_pixel('1, '1, '1);
      set_frame(CFG_W'(2), CFG_W'(2));
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd1, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd254);
      set_frame(CFG_W'(3), CFG_W'(3));
      repeat (9) send_random();
      set_frame(CFG_W'(0), CFG_W'(1));
      send_frame();
      set_frame(CFG_W'(1), CFG_W'(0));
      send_frame();
      set_frame(CFG_W'(3), CFG_W'(1));
      send_frame();

      // Tall narrow frame; the receiver backs off for a long stretch meanwhile.
      set_frame(CFG_W'(2), CFG_W'(64));
      hold_req <= 1'b1;
      send_frame();

      // Random frames, mostly small; now and then resize mid-frame.
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_ITEMS) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12);
         h = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
         set_frame(CFG_W'(w), CFG_W'(h));
         npix = sb.frame_pixels();
         if (npix > 1 && $urandom_range(9) == 0) begin
            cut = $urandom_range(npix - 1, 1);
            repeat (cut) send_random();
            drain();
            write_reg(reg_index_type'($urandom_range(1)), CFG_W'($urandom_range(16)));
            finish_frame();
         end else begin
            send_frame();
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
